// ===== sv/connection_slot_allocator_defines.svh =====
`ifndef CONNECTION_SLOT_ALLOCATOR_DEFINES_SVH
`define CONNECTION_SLOT_ALLOCATOR_DEFINES_SVH

// Assertion helpers. They sample on clk and are switched off while rst_n is low.
`define CSA_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define CSA_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

// ===== sv/csa_pkg.sv =====
package csa_pkg;

  localparam int SLOT_COUNT      = 1024;
  localparam int GENERATION_BITS = 16;

  localparam int SLOT_W     = $clog2(SLOT_COUNT);
  localparam int TOP_W      = $clog2(SLOT_COUNT + 1);
  localparam int GEN_W      = GENERATION_BITS;
  localparam int DESC_MEM_W = 1 + SLOT_W + GEN_W;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_CHECK = 2'd2,
    OP_NOP   = 2'd3
  } csa_op_t;

  typedef enum logic [2:0] {
    STS_DONE    = 3'd0,
    STS_RANGE   = 3'd1,
    STS_LIMIT   = 3'd2,
    STS_BUSY    = 3'd3,
    STS_EMPTY   = 3'd4,
    STS_NOTHING = 3'd5
  } csa_status_t;

  typedef struct packed {
    csa_op_t     operation;
    logic [10:0] descriptor;
    logic        handle_valid;
    logic [9:0]  handle_slot;
  } csa_in_t;

  typedef struct packed {
    csa_status_t status;
    logic        stale;
    logic [9:0]  slot;
    logic [15:0] generation;
    logic [10:0] active_count;
  } csa_out_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } csa_state_t;

  typedef struct packed {
    logic capture;
    logic sel_input;
    logic commit;
    logic clear;
  } csa_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic out_stall;
  } csa_sts_t;

endpackage

// ===== sv/csa_ram.sv =====
module csa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/csa_ctrl.sv =====
module csa_ctrl import csa_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  csa_sts_t sts,
  output csa_cmd_t cmd
);

  csa_state_t state_r;
  csa_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (sts.clear_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (!sts.out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    cmd           = '0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
      end
      ST_IDLE: begin
        in_ready      = 1'b1;
        cmd.sel_input = 1'b1;
        cmd.capture   = in_valid;
      end
      ST_EXEC: begin
        cmd.commit = !sts.out_stall;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ===== sv/csa_dpath.sv =====
module csa_dpath import csa_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  csa_cmd_t    cmd,
  output csa_sts_t    sts,
  input  csa_in_t     in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output csa_out_t    out_data,
  input  logic        cfg_we,
  input  logic [10:0] cfg_wdata
);

  csa_in_t           item_r;
  csa_out_t          out_r;
  csa_out_t          out_nxt;
  logic              out_valid_r;
  logic [TOP_W-1:0]  top_r;
  logic [TOP_W-1:0]  top_nxt;
  logic [TOP_W-1:0]  low_r;
  logic [TOP_W-1:0]  low_nxt;
  logic [10:0]       active_r;
  logic [10:0]       active_nxt;
  logic [10:0]       max_active_r;
  logic [SLOT_W-1:0] clr_idx_r;

  logic [SLOT_W-1:0]     desc_raddr;
  logic [SLOT_W-1:0]     hs_raddr;
  logic [DESC_MEM_W-1:0] desc_rdata;
  logic [DESC_MEM_W-1:0] desc_wdata;
  logic [SLOT_W-1:0]     desc_waddr;
  logic                  desc_we;
  logic [GEN_W-1:0]      sgen_rdata;
  logic [GEN_W-1:0]      sgen_wdata;
  logic [SLOT_W-1:0]     sgen_waddr;
  logic                  sgen_we;
  logic [SLOT_W-1:0]     stack_rdata;
  logic [SLOT_W-1:0]     stack_raddr;
  logic                  stack_we;

  logic                  d_in_range;
  logic                  hs_in_range;
  logic                  mapped;
  logic [SLOT_W-1:0]     map_slot;
  logic [GEN_W-1:0]      dgen;
  logic [GEN_W-1:0]      dgen_nxt;
  logic [SLOT_W-1:0]     pop_slot;
  logic                  ok_alloc;
  logic                  ok_free;

  assign desc_raddr  = cmd.sel_input ? in_data.descriptor[SLOT_W-1:0]
                                     : item_r.descriptor[SLOT_W-1:0];
  assign hs_raddr    = cmd.sel_input ? in_data.handle_slot[SLOT_W-1:0]
                                     : item_r.handle_slot[SLOT_W-1:0];
  assign stack_raddr = SLOT_W'(top_r - TOP_W'(1));

  assign d_in_range  = 32'(item_r.descriptor) < SLOT_COUNT;
  assign hs_in_range = 32'(item_r.handle_slot) < SLOT_COUNT;
  assign {mapped, map_slot, dgen} = desc_rdata;

  // Entries below the lowest stack top ever reached were never written, so their slot is computed, not read.
  assign pop_slot = (top_r == low_r) ? SLOT_W'(SLOT_COUNT - 1) - stack_raddr : stack_rdata;

  always_comb begin
    out_nxt              = '0;
    out_nxt.status       = STS_DONE;
    ok_alloc             = 1'b0;
    ok_free              = 1'b0;
    dgen_nxt             = dgen;
    top_nxt              = top_r;
    low_nxt              = low_r;
    active_nxt           = active_r;
    if (!d_in_range) begin
      out_nxt.status = STS_RANGE;
      out_nxt.stale  = (item_r.operation == OP_CHECK);
    end else begin
      unique case (item_r.operation)
        OP_ALLOC: begin
          priority if (active_r >= max_active_r) begin
            out_nxt.status = STS_LIMIT;
          end else if (mapped) begin
            out_nxt.status = STS_BUSY;
          end else if (top_r == '0) begin
            out_nxt.status = STS_EMPTY;
          end else begin
            ok_alloc     = 1'b1;
            out_nxt.slot = 10'(pop_slot);
            top_nxt      = top_r - TOP_W'(1);
            if (top_nxt < low_r) begin
              low_nxt = top_nxt;
            end
            active_nxt = active_r + 11'd1;
          end
        end
        OP_FREE: begin
          if (!mapped) begin
            out_nxt.status = STS_NOTHING;
          end else begin
            ok_free  = 1'b1;
            dgen_nxt = dgen + GEN_W'(1);
            if (32'(top_r) < SLOT_COUNT) begin
              top_nxt = top_r + TOP_W'(1);
            end
            if (active_r != '0) begin
              active_nxt = active_r - 11'd1;
            end
          end
        end
        OP_CHECK: begin
          out_nxt.stale = !item_r.handle_valid || !mapped || !hs_in_range ||
                          (map_slot != item_r.handle_slot[SLOT_W-1:0]) ||
                          (sgen_rdata != dgen);
        end
        OP_NOP: begin
          out_nxt.status = STS_DONE;
        end
        default: out_nxt.status = STS_DONE;
      endcase
    end
    out_nxt.generation   = d_in_range ? 16'(dgen_nxt) : 16'd0;
    out_nxt.active_count = active_nxt;
  end

  always_comb begin
    desc_we    = 1'b0;
    desc_waddr = item_r.descriptor[SLOT_W-1:0];
    desc_wdata = {ok_alloc, pop_slot, dgen_nxt};
    sgen_we    = 1'b0;
    sgen_waddr = ok_alloc ? pop_slot : map_slot;
    sgen_wdata = ok_alloc ? dgen : '0;
    stack_we   = cmd.commit && ok_free && (32'(top_r) < SLOT_COUNT);
    if (cmd.clear) begin
      desc_we    = 1'b1;
      desc_waddr = clr_idx_r;
      desc_wdata = '0;
      sgen_we    = 1'b1;
      sgen_waddr = clr_idx_r;
      sgen_wdata = '0;
    end else if (cmd.commit && (ok_alloc || ok_free)) begin
      desc_we = 1'b1;
      sgen_we = 1'b1;
    end
  end

  csa_ram #(.WIDTH(DESC_MEM_W), .DEPTH(SLOT_COUNT)) u_desc_mem (
    .clk   (clk),
    .we    (desc_we),
    .waddr (desc_waddr),
    .wdata (desc_wdata),
    .raddr (desc_raddr),
    .rdata (desc_rdata)
  );

  csa_ram #(.WIDTH(GEN_W), .DEPTH(SLOT_COUNT)) u_sgen_mem (
    .clk   (clk),
    .we    (sgen_we),
    .waddr (sgen_waddr),
    .wdata (sgen_wdata),
    .raddr (hs_raddr),
    .rdata (sgen_rdata)
  );

  csa_ram #(.WIDTH(SLOT_W), .DEPTH(SLOT_COUNT)) u_stack_mem (
    .clk   (clk),
    .we    (stack_we),
    .waddr (top_r[SLOT_W-1:0]),
    .wdata (map_slot),
    .raddr (stack_raddr),
    .rdata (stack_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      top_r        <= TOP_W'(SLOT_COUNT);
      low_r        <= TOP_W'(SLOT_COUNT);
      active_r     <= '0;
      max_active_r <= 11'd1024;
      clr_idx_r    <= '0;
    end else begin
      if (cfg_we) begin
        max_active_r <= cfg_wdata;
      end
      if (cmd.clear) begin
        clr_idx_r <= clr_idx_r + SLOT_W'(1);
      end
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
        top_r       <= top_nxt;
        low_r       <= low_nxt;
        active_r    <= active_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r <= in_data;
    end
    if (cmd.commit) begin
      out_r <= out_nxt;
    end
  end

  assign sts.clear_last = (32'(clr_idx_r) == SLOT_COUNT - 1);
  assign sts.out_stall  = out_valid_r && !out_ready;
  assign out_valid      = out_valid_r;
  assign out_data       = out_r;

endmodule

// ===== sv/connection_slot_allocator.sv =====
// Each item is captured in the idle state and its result is committed from the execute state
// into the output register; the commit waits while the previous result is still held there.
// A new item is accepted only after the previous one is committed, as the registered reads
// of the descriptor, slot generation and free stack memories are followed by a write-back.
// Reset: synchronous, active low; afterwards a clearing pass zeroes all 1024 entries of the
// descriptor and slot generation memories, and no item is accepted until it ends.
`include "connection_slot_allocator_defines.svh"

module connection_slot_allocator import csa_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  csa_in_t     in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output csa_out_t    out_data,
  input  logic        cfg_we,
  input  logic [10:0] cfg_wdata
);

  csa_cmd_t cmd;
  csa_sts_t sts;

  csa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  csa_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  `CSA_ASSERT_IMPLY(a_result_latency, $rose(out_valid), $past(in_valid && in_ready, 2), "result without an item two cycles before")
  `CSA_ASSERT_IMPLY(a_stale_status, out_valid && out_data.stale, out_data.status == STS_DONE || out_data.status == STS_RANGE, "stale flag with a refusal status")
  `CSA_ASSERT_NEVER(a_active_bound, out_valid && (32'(out_data.active_count) > SLOT_COUNT), "active count above slot count")
  `CSA_ASSERT_NEVER(a_no_accept_in_clear, cmd.clear && in_ready, "item accepted during clearing pass")

endmodule
